// ===== src/c2rb_pkg.sv =====
// Shared types and constants for the replicate-border 2D convolution unit.
package c2rb_pkg;

  localparam int unsigned MAX_ROWS   = 4096;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned RESULT_CAP = 4;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned RES_W      = 40;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_KWIDTH  = 2'd2,
    REG_KHEIGHT = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAP,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic               [1:0] operation;
    logic               [5:0] coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed  [PIX_W-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic              [9:0] out_x;
    logic             [11:0] out_y;
    logic                    frame_end;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic tap;
    logic finish;
    logic push;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic in_done;
    logic more;
    logic last_tap;
    logic busy;
    logic pend;
    logic out_free;
  } sts_t;

endpackage

// ===== src/c2rb_ctrl.sv =====
// Controller state machine that sequences item decode, kernel taps and result hand-off.
module c2rb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_accept_i,
  input  logic        [1:0] in_op_i,
  input  c2rb_pkg::sts_t    sts_i,
  output c2rb_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);

  c2rb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c2rb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      c2rb_pkg::ST_IDLE: begin
        if (in_accept_i) begin
          if ((in_op_i == c2rb_pkg::OP_PIXEL && !sts_i.in_done) ||
              in_op_i == c2rb_pkg::OP_FLUSH) begin
            state_d = c2rb_pkg::ST_CHECK;
          end
        end
      end
      c2rb_pkg::ST_CHECK: begin
        if (!sts_i.pend || sts_i.out_free) begin
          state_d = sts_i.more ? c2rb_pkg::ST_TAP : c2rb_pkg::ST_IDLE;
        end
      end
      c2rb_pkg::ST_TAP: begin
        if (sts_i.last_tap) begin
          state_d = c2rb_pkg::ST_DRAIN;
        end
      end
      c2rb_pkg::ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = c2rb_pkg::ST_CHECK;
        end
      end
      default: state_d = c2rb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      c2rb_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_accept_i;
      end
      c2rb_pkg::ST_CHECK: begin
        if (sts_i.pend) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_last = !sts_i.more;
            cmd_o.start     = sts_i.more;
          end
        end else begin
          cmd_o.start = sts_i.more;
        end
      end
      c2rb_pkg::ST_TAP: begin
        cmd_o.tap = 1'b1;
      end
      c2rb_pkg::ST_DRAIN: begin
        cmd_o.finish = !sts_i.busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== src/c2rb_datapath.sv =====
// Datapath with registers, kernel table, line store, position counters and the MAC pipeline.
module c2rb_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_KERNEL = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  c2rb_pkg::cmd_t                      cmd_i,
  input  c2rb_pkg::in_word_t                  in_word_i,
  input  logic                                cfg_we_i,
  input  logic      [c2rb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic     [c2rb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                                out_stall_i,
  output c2rb_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  output c2rb_pkg::out_word_t                 out_word_o
);

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW  = c2rb_pkg::ROW_W;
  localparam int unsigned KB  = $clog2(MAX_KERNEL + 1);
  localparam int unsigned SB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned SW  = KB + 2;
  localparam int unsigned TD  = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned TIW = (TD > 1) ? $clog2(TD) : 1;
  localparam int unsigned SD  = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned AW  = $clog2(SD);
  localparam int unsigned XW  = CW + 2;
  localparam int unsigned YW  = RW + 2;

  // Configuration registers and their clamped values.
  logic [10:0] cfg_w_q;
  logic [12:0] cfg_h_q;
  logic  [2:0] cfg_kw_q, cfg_kh_q;
  logic [CW:0] ew;
  logic [RW:0] eh;
  logic [KB-1:0] ekw, ekh;

  always_comb begin
    if (cfg_w_q == '0) begin
      ew = (CW+1)'(1);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      ew = (CW+1)'(MAX_WIDTH);
    end else begin
      ew = (CW+1)'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eh = (RW+1)'(1);
    end else if (32'(cfg_h_q) > 32'(c2rb_pkg::MAX_ROWS)) begin
      eh = (RW+1)'(c2rb_pkg::MAX_ROWS);
    end else begin
      eh = (RW+1)'(cfg_h_q);
    end
    if (cfg_kw_q == '0) begin
      ekw = KB'(1);
    end else if (32'(cfg_kw_q) > 32'(MAX_KERNEL)) begin
      ekw = KB'(MAX_KERNEL);
    end else begin
      ekw = KB'(cfg_kw_q);
    end
    if (cfg_kh_q == '0) begin
      ekh = KB'(1);
    end else if (32'(cfg_kh_q) > 32'(MAX_KERNEL)) begin
      ekh = KB'(MAX_KERNEL);
    end else begin
      ekh = KB'(cfg_kh_q);
    end
  end

  // Stream position state.
  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_row_q, out_row_q;
  logic [SB-1:0] in_slot_q, out_slot_q;
  logic          in_done_q;

  // Item and tap sequencing state.
  logic                       lim4_q;
  logic [c2rb_pkg::CNT_W-1:0] cnt_q;
  logic [KB-1:0]              tj_q, ti_q;
  logic [TIW-1:0]             tk_q;

  // Pending and output result.
  logic                          pend_q;
  logic signed [c2rb_pkg::RES_W-1:0] pend_res_q;
  logic [CW-1:0]                 pend_x_q;
  logic [RW-1:0]                 pend_y_q;
  logic                          pend_fe_q;
  logic                          out_valid_q;
  c2rb_pkg::out_word_t           out_word_q;

  // MAC pipeline.
  logic                               v1_q, v2_q;
  logic signed [c2rb_pkg::PIX_W-1:0]  pix_q;
  logic signed [c2rb_pkg::COEF_W-1:0] coef_q;
  logic signed [c2rb_pkg::PROD_W-1:0] prod_q;
  logic signed [c2rb_pkg::RES_W-1:0]  acc_q;

  logic signed [c2rb_pkg::COEF_W-1:0] ktab [TD];
  logic signed [c2rb_pkg::PIX_W-1:0]  lstore [SD];

  // Readiness of the next output pixel.
  logic [RW:0] ny;
  logic [CW:0] nx;
  logic        ready;
  logic        frame_end;
  logic        out_free;

  always_comb begin
    ny = (RW+1)'(out_row_q) + (RW+1)'(ekh - KB'(1) - (ekh >> 1));
    nx = (CW+1)'(out_col_q) + (CW+1)'(ekw - KB'(1) - (ekw >> 1));
    if (ny > eh - (RW+1)'(1)) begin
      ny = eh - (RW+1)'(1);
    end
    if (nx > ew - (CW+1)'(1)) begin
      nx = ew - (CW+1)'(1);
    end
    ready = in_done_q || (ny < (RW+1)'(in_row_q)) ||
            ((ny == (RW+1)'(in_row_q)) && (nx < (CW+1)'(in_col_q)));
  end

  assign frame_end = ((CW+1)'(out_col_q) == ew - (CW+1)'(1)) &&
                     ((RW+1)'(out_row_q) == eh - (RW+1)'(1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o          = '0;
    sts_o.in_done  = in_done_q;
    sts_o.more     = ready &&
                     (cnt_q < (lim4_q ? c2rb_pkg::CNT_W'(c2rb_pkg::RESULT_CAP)
                                      : c2rb_pkg::CNT_W'(1)));
    sts_o.last_tap = (ti_q == ekw - KB'(1)) && (tj_q == ekh - KB'(1));
    sts_o.busy     = v1_q || v2_q;
    sts_o.pend     = pend_q;
    sts_o.out_free = out_free;
  end

  // Clamped tap address.
  logic signed [YW-1:0] ty;
  logic signed [XW-1:0] tx;
  logic [RW-1:0] sy;
  logic [CW-1:0] sx;
  logic [RW:0]   dy;
  logic [SW-1:0] slot_s;
  logic [SB-1:0] rd_slot;
  logic [AW-1:0] rd_addr, wr_addr;

  always_comb begin
    ty = YW'(out_row_q) + YW'(tj_q) - YW'(ekh >> 1);
    tx = XW'(out_col_q) + XW'(ti_q) - XW'(ekw >> 1);
    if (ty[YW-1]) begin
      sy = '0;
    end else if (ty[YW-2:0] > (YW-1)'(eh - (RW+1)'(1))) begin
      sy = RW'(eh - (RW+1)'(1));
    end else begin
      sy = ty[RW-1:0];
    end
    if (tx[XW-1]) begin
      sx = '0;
    end else if (tx[XW-2:0] > (XW-1)'(ew - (CW+1)'(1))) begin
      sx = CW'(ew - (CW+1)'(1));
    end else begin
      sx = tx[CW-1:0];
    end
    dy     = (RW+1)'(sy) - (RW+1)'(out_row_q);
    slot_s = SW'(out_slot_q) + SW'(MAX_KERNEL) + SW'(dy);
    if (slot_s >= SW'(2 * MAX_KERNEL)) begin
      slot_s = slot_s - SW'(2 * MAX_KERNEL);
    end else if (slot_s >= SW'(MAX_KERNEL)) begin
      slot_s = slot_s - SW'(MAX_KERNEL);
    end
    rd_slot = SB'(slot_s);
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(sx);
    wr_addr = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  end

  logic pix_we, coef_we;

  assign pix_we  = cmd_i.accept && (in_word_i.operation == c2rb_pkg::OP_PIXEL) && !in_done_q;
  assign coef_we = cmd_i.accept && (in_word_i.operation == c2rb_pkg::OP_LOAD) &&
                   (32'(in_word_i.coef_index) < 32'(TD));

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      ktab[TIW'(in_word_i.coef_index)] <= in_word_i.coef_value;
    end
    coef_q <= ktab[tk_q];
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      lstore[wr_addr] <= in_word_i.pixel;
    end
    pix_q <= lstore[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pix_q * coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= 11'd1024;
      cfg_h_q     <= 13'd1024;
      cfg_kw_q    <= 3'd3;
      cfg_kh_q    <= 3'd3;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      in_done_q   <= 1'b0;
      lim4_q      <= 1'b0;
      cnt_q       <= '0;
      tj_q        <= '0;
      ti_q        <= '0;
      tk_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          c2rb_pkg::REG_WIDTH:   cfg_w_q  <= cfg_data_i[10:0];
          c2rb_pkg::REG_HEIGHT:  cfg_h_q  <= cfg_data_i[12:0];
          c2rb_pkg::REG_KWIDTH:  cfg_kw_q <= cfg_data_i[2:0];
          c2rb_pkg::REG_KHEIGHT: cfg_kh_q <= cfg_data_i[2:0];
          default: cfg_w_q <= cfg_w_q;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
        in_done_q  <= 1'b0;
      end

      if (cmd_i.accept) begin
        cnt_q  <= '0;
        lim4_q <= (in_word_i.operation == c2rb_pkg::OP_PIXEL);
      end

      if (pix_we) begin
        if ((CW+1)'(in_col_q) + (CW+1)'(1) >= ew) begin
          in_col_q <= '0;
          if ((RW+1)'(in_row_q) + (RW+1)'(1) >= eh) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
            in_done_q <= 1'b1;
          end else begin
            in_row_q  <= in_row_q + RW'(1);
            in_slot_q <= (32'(in_slot_q) == MAX_KERNEL - 1) ? '0 : in_slot_q + SB'(1);
          end
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end

      if (cmd_i.start) begin
        tj_q  <= '0;
        ti_q  <= '0;
        tk_q  <= '0;
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + c2rb_pkg::RES_W'(prod_q);
      end

      if (cmd_i.tap) begin
        tk_q <= tk_q + TIW'(1);
        if (ti_q == ekw - KB'(1)) begin
          ti_q <= '0;
          tj_q <= tj_q + KB'(1);
        end else begin
          ti_q <= ti_q + KB'(1);
        end
      end
      v1_q <= cmd_i.tap;
      v2_q <= v1_q;

      if (cmd_i.finish) begin
        pend_q     <= 1'b1;
        pend_res_q <= acc_q;
        pend_x_q   <= out_col_q;
        pend_y_q   <= out_row_q;
        pend_fe_q  <= frame_end;
        cnt_q      <= cnt_q + c2rb_pkg::CNT_W'(1);
        if (frame_end) begin
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_slot_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
          in_done_q  <= 1'b0;
        end else if ((CW+1)'(out_col_q) + (CW+1)'(1) >= ew) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + RW'(1);
          out_slot_q <= (32'(out_slot_q) == MAX_KERNEL - 1) ? '0 : out_slot_q + SB'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end

      if (cmd_i.push) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_word_q.result    <= pend_res_q;
      out_word_q.out_x     <= 10'(pend_x_q);
      out_word_q.out_y     <= 12'(pend_y_q);
      out_word_q.frame_end <= pend_fe_q;
      out_word_q.last      <= cmd_i.push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== src/conv2d_replicate_border_unit.sv =====
// Top level of the streaming 2D convolution unit with replicate borders.
//
// Input words arrive on in_valid_i/in_stall_o with in_word_i; a word is taken
// when valid is high and stall is low. A word loads one coefficient, writes
// one pixel in raster order, or flushes one pending output. Result words leave
// on out_valid_o/out_stall_i with out_word_o, up to four per pixel word and one
// per flush word; the last one of each input word has last set.
// Each output pixel is built with one multiply-add per cycle through the single
// MAC pipeline, behind the registered reads of the kernel table and the line
// store. A coefficient load does not stall the input.
// The input side stalls while a word is being worked on. A finished result
// waits in a pending register while the output register is held by a stalled
// receiver; the unit then waits for the output register to drain.
// Reset restores a 1024 x 1024 frame with a 3 x 3 kernel and clears all stream
// positions; kernel table and line store are not cleared. Any register write
// also restarts the stream.
module conv2d_replicate_border_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_KERNEL = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  c2rb_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output c2rb_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic      [c2rb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic     [c2rb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  c2rb_pkg::cmd_t cmd;
  c2rb_pkg::sts_t sts;
  logic           in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  c2rb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_op_i     (in_word_i.operation),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  c2rb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  a_no_pending_on_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_accept |-> !sts.pend
  ) else $error("input word taken while a result is still pending");

  a_push_needs_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.push |-> (!out_valid_o || !out_stall_i)
  ) else $error("result pushed into an occupied output register");

  a_finish_after_drain: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.finish |-> !sts.busy
  ) else $error("output finished while the MAC pipeline is busy");

endmodule

// ===== tb/conv2d_replicate_border_unit_test.sv =====
// Self-checking testbench for the replicate-border 2D convolution unit.
module conv2d_replicate_border_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_KERNEL  = 7;
  localparam int unsigned TABLE_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned SETTLE      = 100;
  localparam int unsigned LONG_HOLD   = 400;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid;
  logic                            in_stall;
  c2rb_pkg::in_word_t              in_word;
  logic                            out_valid;
  logic                            out_stall;
  c2rb_pkg::out_word_t             out_word;
  logic                            cfg_we;
  logic  [c2rb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [c2rb_pkg::CFG_DATA_W-1:0] cfg_data;

  conv2d_replicate_border_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Model state of the unit.
  logic                  [10:0] frame_w_reg;
  logic                  [12:0] frame_h_reg;
  logic                   [2:0] kern_w_reg;
  logic                   [2:0] kern_h_reg;
  logic  [c2rb_pkg::COEF_W-1:0] coef_table [TABLE_DEPTH];
  logic   [c2rb_pkg::PIX_W-1:0] row_store [MAX_KERNEL * MAX_WIDTH];
  int unsigned                  wr_col, wr_row, rd_col, rd_row;
  bit                           frame_in_done;

  c2rb_pkg::out_word_t pending_results[$];
  int unsigned         words_sent, results_seen, frames_done, mismatches;
  int unsigned         send_idle_pct, recv_idle_pct, hold_left;
  event                hold_event;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d words sent and %0d results seen.", words_sent, results_seen);
    $display("** conv2d_replicate_border_unit: FAILED **");
    $finish;
  end

  initial begin
    hold_left = 0;
    forever begin
      @(hold_event);
      hold_left = LONG_HOLD;
      while (hold_left != 0) begin
        @(negedge clk_i);
        hold_left--;
      end
    end
  end

  function automatic int unsigned eff_w();
    return frame_w_reg == 0 ? 1 : (frame_w_reg > MAX_WIDTH ? MAX_WIDTH : frame_w_reg);
  endfunction

  function automatic int unsigned eff_h();
    return frame_h_reg == 0 ? 1 :
           (frame_h_reg > c2rb_pkg::MAX_ROWS ? c2rb_pkg::MAX_ROWS : frame_h_reg);
  endfunction

  function automatic int unsigned eff_kw();
    return kern_w_reg == 0 ? 1 : kern_w_reg;
  endfunction

  function automatic int unsigned eff_kh();
    return kern_h_reg == 0 ? 1 : kern_h_reg;
  endfunction

  function automatic void restart_positions();
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic bit window_complete();
    int unsigned ny, nx;
    ny = rd_row + (eff_kh() - 1 - eff_kh() / 2);
    nx = rd_col + (eff_kw() - 1 - eff_kw() / 2);
    if (frame_in_done) return 1'b1;
    if (ny > eff_h() - 1) ny = eff_h() - 1;
    if (nx > eff_w() - 1) nx = eff_w() - 1;
    return ny < wr_row || (ny == wr_row && nx < wr_col);
  endfunction

  function automatic logic signed [c2rb_pkg::RES_W-1:0] conv_sum();
    int sy, sx;
    logic signed [63:0] acc;
    acc = 0;
    for (int j = 0; j < int'(eff_kh()); j++) begin
      sy = int'(rd_row) + j - int'(eff_kh() / 2);
      sy = sy < 0 ? 0 : (sy > int'(eff_h()) - 1 ? int'(eff_h()) - 1 : sy);
      for (int i = 0; i < int'(eff_kw()); i++) begin
        sx = int'(rd_col) + i - int'(eff_kw() / 2);
        sx = sx < 0 ? 0 : (sx > int'(eff_w()) - 1 ? int'(eff_w()) - 1 : sx);
        acc += $signed(row_store[(sy % MAX_KERNEL) * MAX_WIDTH + sx]) *
               $signed(coef_table[j * eff_kw() + i]);
      end
    end
    return acc[c2rb_pkg::RES_W-1:0];
  endfunction

  function automatic void release_outputs(int unsigned cap);
    int unsigned n;
    c2rb_pkg::out_word_t r;
    n = 0;
    while (n < cap && window_complete()) begin
      r.result    = conv_sum();
      r.out_x     = rd_col[9:0];
      r.out_y     = rd_row[11:0];
      r.frame_end = (rd_col == eff_w() - 1) && (rd_row == eff_h() - 1);
      r.last      = 1'b0;
      pending_results.push_back(r);
      n++;
      if (r.frame_end) begin
        restart_positions();
        frames_done++;
        break;
      end
      rd_col++;
      if (rd_col >= eff_w()) begin
        rd_col = 0;
        rd_row++;
      end
    end
    if (n > 0) pending_results[$].last = 1'b1;
  endfunction

  function automatic void apply_word(c2rb_pkg::in_word_t w);
    case (w.operation)
      c2rb_pkg::OP_LOAD: begin
        if (w.coef_index < TABLE_DEPTH) coef_table[w.coef_index] = w.coef_value;
      end
      c2rb_pkg::OP_PIXEL: begin
        if (!frame_in_done) begin
          row_store[(wr_row % MAX_KERNEL) * MAX_WIDTH + wr_col] = w.pixel;
          wr_col++;
          if (wr_col >= eff_w()) begin
            wr_col = 0;
            wr_row++;
            if (wr_row >= eff_h()) begin
              wr_row = 0;
              frame_in_done = 1'b1;
            end
          end
          release_outputs(c2rb_pkg::RESULT_CAP);
        end
      end
      c2rb_pkg::OP_FLUSH: release_outputs(1);
      default: ;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    c2rb_pkg::out_word_t exp_w;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p.", out_word);
      end else begin
        exp_w = pending_results.pop_front();
        if (exp_w.result !== out_word.result || exp_w.out_x !== out_word.out_x ||
            exp_w.out_y !== out_word.out_y || exp_w.frame_end !== out_word.frame_end ||
            exp_w.last !== out_word.last) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p.", exp_w, out_word);
        end
      end
    end
  end

  task automatic send_word(input c2rb_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    apply_word(w);
    words_sent++;
  endtask

  task automatic send_op(input c2rb_pkg::op_e op, input logic [5:0] idx,
                         input logic [15:0] val);
    c2rb_pkg::in_word_t w;
    w.operation  = op;
    w.coef_index = idx;
    w.coef_value = val;
    w.pixel      = val;
    send_word(w);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input c2rb_pkg::reg_e idx,
                           input logic [c2rb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      c2rb_pkg::REG_WIDTH:   frame_w_reg = val[10:0];
      c2rb_pkg::REG_HEIGHT:  frame_h_reg = val;
      c2rb_pkg::REG_KWIDTH:  kern_w_reg  = val[2:0];
      c2rb_pkg::REG_KHEIGHT: kern_h_reg  = val[2:0];
      default: ;
    endcase
    restart_positions();
  endtask

  task automatic set_geometry(input int w, input int h, input int kw, input int kh);
    drain_results();
    write_reg(c2rb_pkg::REG_WIDTH, c2rb_pkg::CFG_DATA_W'(w));
    write_reg(c2rb_pkg::REG_HEIGHT, c2rb_pkg::CFG_DATA_W'(h));
    write_reg(c2rb_pkg::REG_KWIDTH, c2rb_pkg::CFG_DATA_W'(kw));
    write_reg(c2rb_pkg::REG_KHEIGHT, c2rb_pkg::CFG_DATA_W'(kh));
  endtask

  task automatic flush_frame();
    while (frame_in_done) send_op(c2rb_pkg::OP_FLUSH, 6'($urandom), 16'($urandom));
  endtask

  task automatic test_coefficient_load();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_op(c2rb_pkg::OP_LOAD, 6'(i),
              i == 0 ? 16'h7fff : (i == 1 ? 16'h8000 : 16'($urandom)));
    end
    send_op(c2rb_pkg::OP_LOAD, 6'd63, 16'hffff);
    send_op(c2rb_pkg::OP_LOAD, 6'd49, 16'h0000);
  endtask

  task automatic test_border_cases();
    set_geometry(1, 1, 7, 7);
    send_op(c2rb_pkg::OP_FLUSH, 6'd0, 16'h0000);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h8000);
    set_geometry(3, 2, 3, 3);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h7fff);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h8000);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'hffff);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h0000);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h0001);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h7fff);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h1234);
    begin
      c2rb_pkg::in_word_t w;
      w = c2rb_pkg::in_word_t'({2'd3, 38'($urandom)});
      send_word(w);
    end
    flush_frame();
  endtask

  task automatic test_geometry_extremes();
    set_geometry(2047, 8191, 0, 0);
    repeat (3) send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'($urandom));
    set_geometry(1024, 4096, 7, 7);
    repeat (2) send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'($urandom));
    set_geometry(0, 0, 1, 1);
    send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'h5555);
  endtask

  task automatic test_long_stall();
    set_geometry(8, 4, 3, 3);
    -> hold_event;
    repeat (32) send_op(c2rb_pkg::OP_PIXEL, 6'd0, 16'($urandom));
    flush_frame();
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned roll, frames_before;
    while (words_sent < target) begin
      if (words_sent > target / 3 && words_sent < 2 * target / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 27;
      end else if (words_sent >= 2 * target / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_geometry($urandom_range(1, 9), $urandom_range(1, 6),
                   $urandom_range(0, 7), $urandom_range(0, 7));
      frames_before = frames_done;
      while (!frame_in_done && frames_done == frames_before) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          send_op(c2rb_pkg::OP_LOAD, 6'($urandom_range(63)), 16'($urandom));
        end else if (roll < 8) begin
          send_op(c2rb_pkg::OP_FLUSH, 6'($urandom), 16'($urandom));
        end else if (roll < 10) begin
          send_word(c2rb_pkg::in_word_t'({2'd3, 38'($urandom)}));
        end else begin
          send_op(c2rb_pkg::OP_PIXEL, 6'($urandom), 16'($urandom));
        end
      end
      if ($urandom_range(1)) send_op(c2rb_pkg::OP_PIXEL, 6'($urandom), 16'($urandom));
      flush_frame();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 27;
    recv_idle_pct = 58;
    frame_w_reg   = 11'd1024;
    frame_h_reg   = 13'd1024;
    kern_w_reg    = 3'd3;
    kern_h_reg    = 3'd3;
    restart_positions();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_coefficient_load();
    test_border_cases();
    test_geometry_extremes();
    test_long_stall();
    test_random_frames(395);
    drain_results();

    $display("Sent %0d input words over %0d complete frames; checked %0d result words.",
             words_sent, frames_done, results_seen);
    $display("Covered clamped borders, odd geometry, a long receiver hold and random frames.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** conv2d_replicate_border_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, pending_results.size());
      $display("** conv2d_replicate_border_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/c2rb_pkg.sv
src/c2rb_ctrl.sv
src/c2rb_datapath.sv
src/conv2d_replicate_border_unit.sv
tb/conv2d_replicate_border_unit_test.sv
